### rtl/core/uart_frame_seven_segment_scanner_defines.svh
// Assertion macros shared by the scanner RTL files.
`ifndef UART_FRAME_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define UART_FRAME_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of i_clk once reset has been released.
`define UFSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked on every rising edge of i_clk, reset included.
`define UFSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define UFSS_ASSERT(label, prop, msg)
`define UFSS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### rtl/core/ufss_pkg.sv
// Package with the types, constants and look-up functions of the display scanner.
`timescale 1ns / 1ps

package ufss_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned WORD_W        = 2 * BYTE_W;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam logic [BYTE_W-1:0] FRAME_HEADER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] DIGIT_BASE       = 8'h30;
    localparam logic [BYTE_W-1:0] SEG_BLANK        = 8'hFF;

    // Segment table indices of the two fixed symbols.
    localparam logic [4:0] SEG_IDX_DEGREE = 5'd10;
    localparam logic [4:0] SEG_IDX_LETTER_C = 5'd11;

    // Command codes of an input transaction.
    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef enum logic [1:0] {
        POS_TENS     = 2'd0,
        POS_ONES     = 2'd1,
        POS_DEGREE   = 2'd2,
        POS_LETTER_C = 2'd3
    } t_scan_pos;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic serial_bit;
        logic latch_now;
    } t_out_item;

    // One shift word: segment byte goes out first, then the position select byte.
    typedef struct packed {
        logic [BYTE_W-1:0] segments;
        logic [BYTE_W-1:0] select;
    } t_seg_word;

    typedef struct packed {
        logic      valid;
        t_seg_word word;
    } t_push;

    // Active-low segment patterns; anything beyond the letter C is blank.
    function automatic logic [BYTE_W-1:0] seg_lookup(input logic [4:0] idx);
        logic [BYTE_W-1:0] seg;
        unique case (idx)
            5'd0:             seg = 8'hC0;
            5'd1:             seg = 8'hF9;
            5'd2:             seg = 8'hA4;
            5'd3:             seg = 8'hB0;
            5'd4:             seg = 8'h99;
            5'd5:             seg = 8'h92;
            5'd6:             seg = 8'h82;
            5'd7:             seg = 8'hF8;
            5'd8:             seg = 8'h80;
            5'd9:             seg = 8'h90;
            SEG_IDX_DEGREE:   seg = 8'h9C;
            SEG_IDX_LETTER_C: seg = 8'hC6;
            default:          seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // Active-low digit select for each display position.
    function automatic logic [BYTE_W-1:0] pos_select(input t_scan_pos pos);
        logic [BYTE_W-1:0] sel;
        unique case (pos)
            POS_TENS:     sel = 8'hF7;
            POS_ONES:     sel = 8'hFB;
            POS_DEGREE:   sel = 8'hFD;
            POS_LETTER_C: sel = 8'hFE;
            default:      sel = 8'hFF;
        endcase
        return sel;
    endfunction

endpackage

### rtl/core/uart_frame_seven_segment_scanner.sv
// Top level of the serial-frame fed, multiplexed seven-segment display scanner.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_data  (command, rx_byte)
// output    out        o_valid / i_stall    o_data  (serial_bit, latch_now)
// config    in         i_cfg_wr_en          i_cfg_wr_data (frame header)
//
// A received-byte transaction produces no output. A refresh tick produces 16 output
// transactions, one per cycle while i_stall is low, from the shift register in the back
// end; back-to-back ticks stream out with no gap between their words.
// Reset is synchronous and active low; it clears the frame state, the shown value,
// the scan position and the queue, and sets the frame header to 0xAA. No clearing pass.
// The input is stalled only while the word queue is full; the output side may stall
// at any time and simply holds the current bit.

module uart_frame_seven_segment_scanner #(
    parameter int unsigned QUEUE_DEPTH = ufss_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ufss_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output ufss_pkg::t_out_item o_data,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data
);
    import ufss_pkg::*;

    t_push     push;
    logic      q_full;
    logic      q_not_empty;
    logic      q_pop;
    t_seg_word q_word;

    // The front end handles frames in arrival order, so a tick always sees the value
    // left by every byte accepted before it, and it pushes a finished 16-bit word.
    ufss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data        (i_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_push        (push)
    );

    // The queue lets the front end keep taking bytes and ticks while the shifter is busy.
    ufss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_word      (q_word)
    );

    // The back end drives each word out MSB first: segment byte, then select byte.
    ufss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_word      (q_word),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data        (o_data)
    );

endmodule

### rtl/core/ufss_front.sv
// Front end: takes input transactions, assembles frames and builds shift words for ticks.
`timescale 1ns / 1ps

module ufss_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ufss_pkg::t_in_item i_data,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    input  logic              i_q_full,
    output ufss_pkg::t_push   o_push
);
    import ufss_pkg::*;

    logic [BYTE_W-1:0] r_frame_header;
    logic [1:0]        r_byte_count;
    logic [BYTE_W-1:0] r_frame_bytes [2];
    logic [BYTE_W-1:0] r_shown_value;
    t_scan_pos         r_scan_pos;

    logic              accept;
    logic [BYTE_W-1:0] tens_byte;
    logic [BYTE_W-1:0] ones_byte;
    logic [BYTE_W-1:0] n_shown_value;
    logic [15:0]       recip_prod;
    logic [4:0]        tens_digit;
    logic [BYTE_W-1:0] tens_times_ten;
    logic [BYTE_W-1:0] ones_full;
    logic [4:0]        seg_idx;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !o_stall;

    // Value carried by a complete frame, wrapping modulo 256.
    always_comb begin
        tens_byte     = r_frame_bytes[1] - DIGIT_BASE;
        ones_byte     = i_data.rx_byte - DIGIT_BASE;
        n_shown_value = {tens_byte[4:0], 3'b000} + {tens_byte[6:0], 1'b0} + ones_byte;
    end

    // Split the shown value into decimal digits: value * 205 >> 11 is exact below 1029.
    always_comb begin
        recip_prod     = 16'(r_shown_value) * 16'd205;
        tens_digit     = recip_prod[15:11];
        tens_times_ten = {tens_digit, 3'b000} + {2'b00, tens_digit, 1'b0};
        ones_full      = r_shown_value - tens_times_ten;
    end

    always_comb begin
        unique case (r_scan_pos)
            POS_TENS:     seg_idx = tens_digit;
            POS_ONES:     seg_idx = {1'b0, ones_full[3:0]};
            POS_DEGREE:   seg_idx = SEG_IDX_DEGREE;
            POS_LETTER_C: seg_idx = SEG_IDX_LETTER_C;
            default:      seg_idx = SEG_IDX_DEGREE;
        endcase
        o_push.valid         = accept && (i_data.command == CMD_TICK);
        o_push.word.segments = seg_lookup(seg_idx);
        o_push.word.select   = pos_select(r_scan_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_header <= FRAME_HEADER_RST;
            r_byte_count   <= 2'd0;
            r_shown_value  <= '0;
            r_scan_pos     <= POS_TENS;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_header <= i_cfg_wr_data;
            end
            if (accept) begin
                if (i_data.command == CMD_TICK) begin
                    r_scan_pos <= t_scan_pos'(2'(r_scan_pos) + 2'd1);
                end else if (r_byte_count < 2'd2) begin
                    r_byte_count <= r_byte_count + 2'd1;
                end else begin
                    if (r_frame_bytes[0] == r_frame_header) begin
                        r_shown_value <= n_shown_value;
                    end
                    r_byte_count <= 2'd0;
                end
            end
        end
    end

    // Frame bytes are always written before they are read, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (accept && (i_data.command == CMD_RX_BYTE) && (r_byte_count < 2'd2)) begin
            r_frame_bytes[r_byte_count[0]] <= i_data.rx_byte;
        end
    end

endmodule

### rtl/core/ufss_queue.sv
// Small first-in first-out queue of shift words between front end and shifter.
`timescale 1ns / 1ps
`include "uart_frame_seven_segment_scanner_defines.svh"

module ufss_queue #(
    parameter int unsigned DEPTH = ufss_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ufss_pkg::t_push     i_push,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_not_empty,
    output ufss_pkg::t_seg_word o_word
);
    import ufss_pkg::*;

    // DEPTH must be a power of two of at least two, so the pointers wrap on their own; the block does not check it.
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_seg_word        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_word      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push.valid && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push.valid && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    `UFSS_ASSERT(a_no_push_when_full, (r_count == CNT_W'(DEPTH)) |-> !i_push.valid, "overrun")
    `UFSS_ASSERT(a_no_pop_when_empty, (r_count == '0) |-> !i_pop, "queue underrun")
    `UFSS_ASSERT_ALWAYS(a_count_ok, !i_rst_n || (r_count <= CNT_W'(DEPTH)), "bad count")

endmodule

### rtl/core/ufss_back.sv
// Back end: shifts each queued word out one bit per transaction, latch mark on the last.
`timescale 1ns / 1ps
`include "uart_frame_seven_segment_scanner_defines.svh"

module ufss_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_not_empty,
    input  ufss_pkg::t_seg_word i_q_word,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output ufss_pkg::t_out_item o_data
);
    import ufss_pkg::*;

    localparam int unsigned BIT_CNT_W = $clog2(WORD_W);

    logic [WORD_W-1:0]    r_word;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic                 r_busy;

    logic take_out;
    logic last_bit;

    assign take_out = r_busy && !i_stall;
    assign last_bit = (r_bit_cnt == BIT_CNT_W'(WORD_W - 1));
    // A new word loads while idle, or straight after the last bit of the current one leaves.
    assign o_pop    = i_q_not_empty && (!r_busy || (take_out && last_bit));

    assign o_valid           = r_busy;
    assign o_data.serial_bit = r_word[WORD_W-1];
    assign o_data.latch_now  = last_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_bit_cnt <= '0;
        end else if (o_pop) begin
            r_busy    <= 1'b1;
            r_bit_cnt <= '0;
        end else if (take_out) begin
            if (last_bit) begin
                r_busy <= 1'b0;
            end
            r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_q_word;
        end else if (take_out) begin
            r_word <= {r_word[WORD_W-2:0], 1'b0};
        end
    end

    `UFSS_ASSERT(a_idle_end, take_out && last_bit && !i_q_not_empty |=> !o_valid, "shifter busy")

endmodule

### verif/uart_frame_seven_segment_scanner_tb.sv
// Self-checking testbench for the serial-frame fed seven-segment display scanner.
`timescale 1ns / 1ps

// The stimulus is planned up front into a queue of pending actions: input
// transactions, pauses that wait for the output side to drain, and writes of the
// frame header register. A clocked driver works through that queue with random
// gaps. As each input transaction is accepted, the driver runs it through a local
// copy of the scanner state and appends the sixteen expected shift bits of every
// refresh tick to a queue. A clocked monitor stalls the output at random and
// compares every accepted output transaction with the oldest expected bit.
module uart_frame_seven_segment_scanner_tb;

    import ufss_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    // A received byte is absorbed as it is accepted, so a short settling
    // time after the last output transaction is enough before a header write.
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 66;
    localparam int NUM_PHASES     = 5;

    // Active-low segment patterns for indices 0 to 11, index 0 in the low byte.
    localparam logic [12*8-1:0] SEGMENT_CODES = {
        8'hC6, 8'h9C, 8'h90, 8'h80, 8'hF8, 8'h82,
        8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };
    // Active-low position select bytes: tens, ones, degree sign, letter C.
    localparam logic [4*8-1:0] DIGIT_SELECTS = {8'hFE, 8'hFD, 8'hFB, 8'hF7};

    typedef enum logic [1:0] {
        PLAN_ITEM,
        PLAN_DRAIN,
        PLAN_HEADER
    } t_plan_kind;

    typedef struct {
        t_plan_kind kind;
        t_in_item   item;
        logic [7:0] header;
    } t_plan_entry;

    // Block ports. Every input carries a known value from time zero.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    t_in_item    i_data        = '0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;

    // Pending actions and the expected shift bits.
    t_plan_entry plan_q[$];
    t_out_item   shift_bits_q[$];
    int          plan_fill;
    int          planned_items;

    // Local copy of the scanner state, advanced once per accepted input transaction.
    logic [7:0]  header_copy;
    logic [1:0]  frame_fill;
    logic [7:0]  frame_held [2];
    logic [7:0]  shown_copy;
    t_scan_pos   next_pos;

    // Pacing state of the two sides.
    int          send_wait;
    int          settle_count;
    logic        send_burst;
    int          stall_left;
    logic        recv_burst;
    int          stuck_cycles;
    int          error_count = 0;

    uart_frame_seven_segment_scanner i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data        (i_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data        (o_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial forever #CLK_HALF i_clk = ~i_clk;

    // Advances the local scanner state by one input transaction. A received byte
    // only moves the frame along; a refresh tick queues the sixteen bits of the
    // word for the current position, segment byte first, and moves to the next one.
    function automatic void predict_scanner(input t_in_item item);
        logic [7:0]  tens;
        logic [7:0]  ones;
        logic [7:0]  digit;
        logic [7:0]  segments;
        logic [15:0] word;
        t_out_item   bit_out;
        if (item.command == CMD_RX_BYTE) begin
            if (frame_fill < 2'd2) begin
                frame_held[frame_fill[0]] = item.rx_byte;
                frame_fill = frame_fill + 2'd1;
            end else begin
                // The third byte closes the frame whether or not the header matches.
                if (frame_held[0] == header_copy) begin
                    tens = frame_held[1] - DIGIT_BASE;
                    ones = item.rx_byte - DIGIT_BASE;
                    tens = tens * 8'd10;
                    shown_copy = tens + ones;
                end
                frame_fill = 2'd0;
            end
        end else begin
            case (next_pos)
                POS_TENS:   digit = shown_copy / 8'd10;
                POS_ONES:   digit = shown_copy % 8'd10;
                POS_DEGREE: digit = 8'd10;
                default:    digit = 8'd11;
            endcase
            // Values of 120 and above give a tens index past the table, shown blank.
            segments = (digit > 8'd11) ? SEG_BLANK : SEGMENT_CODES[digit*8 +: 8];
            word = {segments, DIGIT_SELECTS[next_pos*8 +: 8]};
            for (int k = 0; k < 16; k++) begin
                bit_out.serial_bit = word[15-k];
                bit_out.latch_now  = (k == 15);
                shift_bits_q.push_back(bit_out);
            end
            next_pos = t_scan_pos'(next_pos + 2'd1);
        end
    endfunction

    // Planning helpers. plan_fill follows the frame position so that well-formed
    // frames can be lined up after stray bytes.
    function automatic void plan_byte(input logic [7:0] value);
        t_plan_entry entry;
        entry.kind           = PLAN_ITEM;
        entry.item.command   = CMD_RX_BYTE;
        entry.item.rx_byte   = value;
        entry.header         = '0;
        plan_q.push_back(entry);
        plan_fill = (plan_fill == 2) ? 0 : plan_fill + 1;
        planned_items++;
    endfunction

    function automatic void plan_tick();
        t_plan_entry entry;
        entry.kind           = PLAN_ITEM;
        entry.item.command   = CMD_TICK;
        // The byte field is ignored on a tick, so it carries noise.
        entry.item.rx_byte   = 8'($urandom);
        entry.header         = '0;
        plan_q.push_back(entry);
        planned_items++;
    endfunction

    function automatic void plan_frame(input logic [7:0] head, input logic [7:0] first,
                                       input logic [7:0] second);
        while (plan_fill != 0)
            plan_byte(8'($urandom));
        plan_byte(head);
        plan_byte(first);
        plan_byte(second);
    endfunction

    function automatic void plan_control(input t_plan_kind kind, input logic [7:0] value);
        t_plan_entry entry;
        entry.kind   = kind;
        entry.item   = '0;
        entry.header = value;
        plan_q.push_back(entry);
    endfunction

    // Mostly an ASCII digit, now and then any byte so that the arithmetic wraps.
    function automatic logic [7:0] random_digit();
        if ($urandom_range(0, 9) < 8)
            return DIGIT_BASE + 8'($urandom_range(0, 9));
        return 8'($urandom);
    endfunction

    // Gap before the next input transaction: mostly none or short, a few long,
    // with stretches in which the sender never pauses.
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            send_burst = !send_burst;
        if (send_burst || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver. It also runs the prediction, since it sees each accepted transaction.
    // All outputs are worked out in local variables and assigned once per edge.
    always @(posedge i_clk) begin : driver
        logic       drive_valid;
        t_in_item   drive_data;
        logic       drive_cfg_en;
        logic [7:0] drive_cfg_data;
        if (!i_rst_n) begin
            header_copy   = FRAME_HEADER_RST;
            frame_fill    = 2'd0;
            frame_held[0] = '0;
            frame_held[1] = '0;
            shown_copy    = '0;
            next_pos      = POS_TENS;
            send_wait     = 0;
            settle_count  = 0;
            send_burst    = 1'b0;
            i_valid       <= 1'b0;
            i_cfg_wr_en   <= 1'b0;
        end else begin
            drive_valid    = i_valid;
            drive_data     = i_data;
            drive_cfg_en   = 1'b0;
            drive_cfg_data = i_cfg_wr_data;
            if (i_valid && !o_stall) begin
                predict_scanner(i_data);
                drive_valid = 1'b0;
                send_wait   = sender_gap();
            end
            if (!drive_valid && plan_q.size() != 0) begin
                if (send_wait != 0) begin
                    send_wait--;
                end else begin
                    case (plan_q[0].kind)
                        PLAN_ITEM: begin
                            drive_valid = 1'b1;
                            drive_data  = plan_q[0].item;
                            plan_q.delete(0);
                        end
                        PLAN_DRAIN: begin
                            // Hold off until every expected bit has come, then settle.
                            if (shift_bits_q.size() != 0) begin
                                settle_count = 0;
                            end else if (settle_count < SETTLE_CYCLES) begin
                                settle_count++;
                            end else begin
                                settle_count = 0;
                                plan_q.delete(0);
                            end
                        end
                        default: begin
                            drive_cfg_en   = 1'b1;
                            drive_cfg_data = plan_q[0].header;
                            header_copy    = plan_q[0].header;
                            plan_q.delete(0);
                        end
                    endcase
                end
            end
            i_valid       <= drive_valid;
            i_data        <= drive_data;
            i_cfg_wr_en   <= drive_cfg_en;
            i_cfg_wr_data <= drive_cfg_data;
        end
    end

    // Monitor. Checks each accepted output transaction against the oldest
    // expected bit, then chooses the stall for the next cycle.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        logic      hold;
        if (!i_rst_n) begin
            stall_left = 0;
            recv_burst = 1'b0;
            i_stall    <= 1'b0;
        end else begin
            if (o_valid === 1'b1 && !i_stall) begin
                if (shift_bits_q.size() == 0) begin
                    $error("output transaction with nothing expected: serial_bit %0b latch_now %0b",
                           o_data.serial_bit, o_data.latch_now);
                    error_count++;
                end else begin
                    want = shift_bits_q.pop_front();
                    if (o_data.serial_bit !== want.serial_bit) begin
                        $error("serial_bit: expected %0b, got %0b",
                               want.serial_bit, o_data.serial_bit);
                        error_count++;
                    end
                    if (o_data.latch_now !== want.latch_now) begin
                        $error("latch_now: expected %0b, got %0b",
                               want.latch_now, o_data.latch_now);
                        error_count++;
                    end
                end
            end
            // Now and then switch into or out of a stretch with no stalls at all.
            if ($urandom_range(0, 199) == 0)
                recv_burst = !recv_burst;
            if (stall_left != 0) begin
                hold = 1'b1;
                stall_left--;
            end else if (!recv_burst && $urandom_range(0, 99) < 20) begin
                hold       = 1'b1;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(0, 2);
            end else begin
                hold = 1'b0;
            end
            i_stall <= hold;
        end
    end

    // Watchdog: ends the run if no transaction of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck_cycles <= 0;
        end else if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall) || i_cfg_wr_en) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("uart_frame_seven_segment_scanner_tb NOT OK");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] phase_header [NUM_PHASES];
        int         phase_start;
        int         pick;
        logic       paused_mid;
        plan_fill     = 0;
        planned_items = 0;
        paused_mid    = 1'b0;

        // Directed part, under the reset header. First all four positions with
        // the value at zero.
        repeat (4) plan_tick();
        // 110: the tens index lands on the letter C pattern.
        plan_frame(FRAME_HEADER_RST, 8'h3B, 8'h30);
        plan_tick();
        plan_tick();
        // Bytes outside the digit range wrap to 230, whose tens index is past the
        // table and therefore blank.
        plan_frame(FRAME_HEADER_RST, 8'hFF, 8'h00);
        plan_tick();
        plan_tick();
        // A frame with the wrong header must leave 230 on the display.
        plan_frame(8'h55, 8'h30, 8'h35);
        plan_tick();
        plan_tick();
        // 109: the tens index lands on the degree pattern.
        plan_frame(FRAME_HEADER_RST, 8'h3A, 8'h39);
        repeat (4) plan_tick();

        // Random part, in phases with different headers, the extremes among them.
        phase_header[0] = 8'h00;
        phase_header[1] = 8'hFF;
        phase_header[2] = 8'($urandom);
        phase_header[3] = 8'($urandom);
        phase_header[4] = FRAME_HEADER_RST;
        for (int p = 0; p < NUM_PHASES; p++) begin
            plan_control(PLAN_DRAIN, '0);
            plan_control(PLAN_HEADER, phase_header[p]);
            phase_start = planned_items;
            while (planned_items - phase_start < PHASE_ITEMS) begin
                // Once, halfway through a phase, let the output side empty out.
                if (p == 2 && !paused_mid && planned_items - phase_start >= PHASE_ITEMS / 2) begin
                    plan_control(PLAN_DRAIN, '0);
                    paused_mid = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    plan_frame(phase_header[p], random_digit(), random_digit());
                else if (pick < 70)
                    plan_frame(8'($urandom), random_digit(), random_digit());
                else if (pick < 82)
                    repeat ($urandom_range(1, 2)) plan_byte(8'($urandom));
                repeat ($urandom_range(0, 4)) plan_tick();
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sampled on the falling edge, clear of the updates made at the rising one.
        do
            @(negedge i_clk);
        while (plan_q.size() != 0 || i_valid || shift_bits_q.size() != 0);
        repeat (END_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("uart_frame_seven_segment_scanner_tb OK");
        end else begin
            $display("uart_frame_seven_segment_scanner_tb NOT OK");
        end
        $finish;
    end

endmodule
